@@ rtl/dpfc_pkg.sv @@
package dpfc_pkg;

  // Counter and register widths
  localparam int unsigned CountWidth = 16;
  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned IdxWidth   = 2;
  localparam int unsigned Lanes      = 5;

  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  // Reset values of the configuration registers
  localparam logic [CfgWidth-1:0] DebounceReset  = CfgWidth'(50);
  localparam logic [CfgWidth-1:0] PumpDelayReset = CfgWidth'(3000);

  // Configuration register indexes
  localparam logic [IdxWidth-1:0] CFG_DEBOUNCE   = IdxWidth'(0);
  localparam logic [IdxWidth-1:0] CFG_PUMP_DELAY = IdxWidth'(1);

  // Lane order
  localparam int unsigned LANE_START = 0;
  localparam int unsigned LANE_STOP  = 1;
  localparam int unsigned LANE_EMERG = 2;
  localparam int unsigned LANE_LOW   = 3;
  localparam int unsigned LANE_HIGH  = 4;

  // Mode codes as seen on the output
  localparam logic [2:0] CODE_IDLE  = 3'd0;
  localparam logic [2:0] CODE_RUN   = 3'd1;
  localparam logic [2:0] CODE_DELAY = 3'd2;
  localparam logic [2:0] CODE_FILL  = 3'd3;
  localparam logic [2:0] CODE_FULL  = 3'd4;
  localparam logic [2:0] CODE_EMERG = 3'd5;

  // Controller states, one-hot
  typedef enum logic [5:0] {
    MODE_IDLE  = 6'b000001,
    MODE_RUN   = 6'b000010,
    MODE_DELAY = 6'b000100,
    MODE_FILL  = 6'b001000,
    MODE_FULL  = 6'b010000,
    MODE_EMERG = 6'b100000
  } mode_e;

  typedef struct packed {
    logic start_level;
    logic stop_level;
    logic emergency_level;
    logic low_level;
    logic high_level;
  } in_item_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       delay_lamp;
    logic       pump_on;
    logic       full_lamp;
    logic       alarm;
  } out_item_t;

  // What the debounce lanes hand to the mode controller
  typedef struct packed {
    logic [Lanes-1:0] press;
    logic [Lanes-1:0] stable;
  } lanes_t;

  function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
    sat_inc = (v == CountMax) ? v : v + CountWidth'(1);
  endfunction

endpackage

@@ rtl/dpfc_lane.sv @@
module dpfc_lane import dpfc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                raw_i,
  input  logic [CfgWidth-1:0] debounce_i,
  output logic                press_o,
  output logic                stable_o
);

  logic                  last_q, last_d;
  logic                  stable_q, stable_d;
  logic [CountWidth-1:0] quiet_q, quiet_d;

  // Quiet counter restarts on a raw change, otherwise saturates upwards
  always_comb begin
    last_d   = raw_i;
    quiet_d  = (raw_i != last_q) ? '0 : sat_inc(quiet_q);
    stable_d = stable_q;
    press_o  = 1'b0;
    if ((quiet_d >= debounce_i) && (raw_i != stable_q)) begin
      stable_d = raw_i;
      press_o  = ~raw_i;
    end
  end

  // Stable level of this tick, as the controller sees it
  assign stable_o = stable_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= 1'b1;
      stable_q <= 1'b1;
      quiet_q  <= '0;
    end else if (en_i) begin
      last_q   <= last_d;
      stable_q <= stable_d;
      quiet_q  <= quiet_d;
    end
  end

endmodule

@@ rtl/dpfc_mode.sv @@
module dpfc_mode import dpfc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  lanes_t              lanes_i,
  input  logic [CfgWidth-1:0] pump_delay_i,
  output out_item_t           result_o
);

  mode_e                 mode_q, mode_d;
  logic [CountWidth-1:0] delay_q, delay_d;

  // Next mode: emergency first, then stop, start, sensors and the delay timer
  always_comb begin
    mode_d  = mode_q;
    delay_d = delay_q;

    if (lanes_i.press[LANE_EMERG]) begin
      mode_d = (mode_q != MODE_EMERG) ? MODE_EMERG : MODE_IDLE;
    end

    if (mode_d != MODE_EMERG) begin
      if (lanes_i.press[LANE_STOP]) begin
        mode_d = MODE_IDLE;
      end
      if (lanes_i.press[LANE_START] && (mode_d == MODE_IDLE || mode_d == MODE_FULL)) begin
        mode_d = MODE_RUN;
      end

      if (!lanes_i.stable[LANE_HIGH] &&
          (mode_d == MODE_RUN || mode_d == MODE_DELAY || mode_d == MODE_FILL)) begin
        mode_d = MODE_FULL;
      end else if (!lanes_i.stable[LANE_LOW] && (mode_d == MODE_RUN || mode_d == MODE_FULL)) begin
        mode_d  = MODE_DELAY;
        delay_d = '0;
      end

      if (mode_d == MODE_DELAY) begin
        if (delay_d >= pump_delay_i) begin
          mode_d = MODE_FILL;
        end else begin
          delay_d = sat_inc(delay_d);
        end
      end
    end
  end

  // Output code and lamps follow the new mode
  always_comb begin
    result_o = '0;
    unique case (mode_d)
      MODE_IDLE:  result_o.mode = CODE_IDLE;
      MODE_RUN:   result_o.mode = CODE_RUN;
      MODE_DELAY: result_o.mode = CODE_DELAY;
      MODE_FILL:  result_o.mode = CODE_FILL;
      MODE_FULL:  result_o.mode = CODE_FULL;
      MODE_EMERG: result_o.mode = CODE_EMERG;
      default:    result_o.mode = CODE_IDLE;
    endcase
    result_o.delay_lamp = (mode_d == MODE_DELAY);
    result_o.pump_on    = (mode_d == MODE_FILL);
    result_o.full_lamp  = (mode_d == MODE_FULL);
    result_o.alarm      = (mode_d == MODE_EMERG);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      delay_q <= '0;
    end else if (en_i) begin
      mode_q  <= mode_d;
      delay_q <= delay_d;
    end
  end

endmodule

@@ rtl/debounced_pump_fill_controller_unit.sv @@
// Pump fill controller with five debounced active-low inputs. One tick item
// is accepted per clock cycle; its result (mode and lamps) appears in the
// output register on the next cycle. The five debounce lanes and the mode
// controller compute the result combinationally, so the only thing that holds
// input back is a result still waiting in the output register while the
// receiver keeps out_ready_i low. Write configuration only while idle.
module debounced_pump_fill_controller_unit import dpfc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [IdxWidth-1:0] cfg_index_i,
  input  logic [CfgWidth-1:0] cfg_data_i
);

  logic                in_fire;
  logic [Lanes-1:0]    raw;
  lanes_t              lanes;
  out_item_t           result;
  logic [CfgWidth-1:0] debounce_q, pump_delay_q;
  logic                out_valid_q;
  out_item_t           out_data_q;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DebounceReset;
      pump_delay_q <= PumpDelayReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DEBOUNCE:   debounce_q   <= cfg_data_i;
        CFG_PUMP_DELAY: pump_delay_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Raw levels in lane order
  always_comb begin
    raw             = '1;
    raw[LANE_START] = in_data_i.start_level;
    raw[LANE_STOP]  = in_data_i.stop_level;
    raw[LANE_EMERG] = in_data_i.emergency_level;
    raw[LANE_LOW]   = in_data_i.low_level;
    raw[LANE_HIGH]  = in_data_i.high_level;
  end

  // Debounce lanes
  for (genvar g = 0; g < Lanes; g++) begin : g_lane
    dpfc_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (in_fire),
      .raw_i      (raw[g]),
      .debounce_i (debounce_q),
      .press_o    (lanes.press[g]),
      .stable_o   (lanes.stable[g])
    );
  end

  // Mode controller merges the lane events
  dpfc_mode u_mode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (in_fire),
    .lanes_i      (lanes),
    .pump_delay_i (pump_delay_q),
    .result_o     (result)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Checks
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o) else $error("accepted tick gave no result");

  a_one_lamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({out_data_o.delay_lamp, out_data_o.pump_on,
                              out_data_o.full_lamp, out_data_o.alarm}))
    else $error("more than one lamp lit");

  a_alarm_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.alarm == (out_data_o.mode == CODE_EMERG)))
    else $error("alarm disagrees with mode");

  a_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule

@@ test/tb_debounced_pump_fill_controller_unit.sv @@
`timescale 1ns / 1ps

module tb_debounced_pump_fill_controller_unit;
  import dpfc_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned NumRows    = 26;
  localparam int unsigned CfgRow     = 2;  // rows before this one run on reset thresholds
  localparam int unsigned NumPhases  = 7;
  localparam int unsigned HoldPhase  = 1;  // phase in which the sender waits for all results

  // Register indexes beyond the two real ones; writes to them must be ignored
  localparam logic [IdxWidth-1:0] CFG_SPARE_LO = IdxWidth'(2);
  localparam logic [IdxWidth-1:0] CFG_SPARE_HI = IdxWidth'(3);

  // Directed tick: levels in field order {start, stop, emergency, low, high}
  typedef struct packed {
    logic [Lanes-1:0] levels;
    logic             typed;
    logic [2:0]       mode;
  } tick_row_t;

  typedef struct packed {
    logic [15:0] deb;
    logic [15:0] pump;
    logic [7:0]  snd_idle;
    logic [7:0]  rcv_stall;
    logic [15:0] ticks;
    logic        poke_spare;
  } phase_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                tick_valid = 1'b0;
  logic                tick_ready;
  in_item_t            tick_data = '1;
  logic                res_valid;
  logic                res_ready = 1'b0;
  out_item_t           res_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [IdxWidth-1:0] cfg_index = '0;
  logic [CfgWidth-1:0] cfg_data = '0;

  // Typed-in expectation travelling alongside the tick payload
  logic      row_typed = 1'b0;
  out_item_t row_result = '0;

  // Controller model state
  logic [Lanes-1:0]      raw_prev;
  logic [Lanes-1:0]      lvl_stable;
  logic [CountWidth-1:0] quiet_cnt [Lanes];
  logic [2:0]            ctl_mode;
  logic [CountWidth-1:0] delay_cnt;
  logic [CfgWidth-1:0]   debounce_thr;
  logic [CfgWidth-1:0]   pump_thr;

  out_item_t   expected_modes [$];
  int unsigned n_errors = 0;
  int unsigned n_ticks = 0;
  int unsigned n_results = 0;
  int unsigned n_settings = 0;
  int unsigned cycles = 0;
  int unsigned mode_hits [8] = '{default: 0};
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_stall_pct = 0;

  // Only the rows right after reset carry a typed-in result; the rest go to the predictor
  tick_row_t dir_rows [NumRows] = '{
    '{5'b00000, 1'b1, CODE_IDLE},   // all pressed, far too short for the reset debounce
    '{5'b00000, 1'b1, CODE_IDLE},
    '{5'b11111, 1'b1, CODE_IDLE},   // zero thresholds from here on
    '{5'b01111, 1'b0, CODE_RUN},    // start accepted on the change tick
    '{5'b11111, 1'b0, CODE_RUN},
    '{5'b11101, 1'b0, CODE_FILL},   // low water, zero pump delay fills at once
    '{5'b11100, 1'b0, CODE_FULL},   // high water wins over filling
    '{5'b11100, 1'b0, CODE_FILL},   // full with low water still restarts the delay
    '{5'b11110, 1'b0, CODE_FULL},
    '{5'b11110, 1'b0, CODE_FULL},
    '{5'b10110, 1'b0, CODE_IDLE},   // stop
    '{5'b11111, 1'b0, CODE_IDLE},
    '{5'b11011, 1'b0, CODE_EMERG},
    '{5'b01011, 1'b0, CODE_EMERG},  // start ignored in emergency
    '{5'b11111, 1'b0, CODE_EMERG},
    '{5'b11011, 1'b0, CODE_IDLE},   // second emergency press toggles back
    '{5'b11111, 1'b0, CODE_IDLE},
    '{5'b00111, 1'b0, CODE_RUN},    // stop and start together: start wins
    '{5'b11111, 1'b0, CODE_RUN},
    '{5'b11011, 1'b0, CODE_EMERG},
    '{5'b11111, 1'b0, CODE_EMERG},
    '{5'b01011, 1'b0, CODE_RUN},    // leaving emergency lets start act on the same tick
    '{5'b11111, 1'b0, CODE_RUN},
    '{5'b11110, 1'b0, CODE_FULL},
    '{5'b11101, 1'b0, CODE_FILL},   // high clears and low appears on one tick
    '{5'b01101, 1'b0, CODE_FILL}    // start does nothing while filling
  };

  phase_t phases [NumPhases] = '{
    '{16'd0,     16'd0,     8'd0,  8'd0,  16'd70, 1'b0},
    '{16'd2,     16'd5,     8'd77, 8'd0,  16'd90, 1'b0},
    '{16'd1,     16'd12,    8'd0,  8'd77, 16'd90, 1'b1},
    '{16'd3,     16'd65535, 8'd17, 8'd17, 16'd60, 1'b0},
    '{16'd65535, 16'd2,     8'd0,  8'd0,  16'd40, 1'b0},
    '{16'd4,     16'd8,     8'd17, 8'd17, 16'd80, 1'b1},
    '{16'd0,     16'd1,     8'd0,  8'd0,  16'd70, 1'b0}
  };

  debounced_pump_fill_controller_unit DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (tick_valid),
    .in_ready_o (tick_ready),
    .in_data_i  (tick_data),
    .out_valid_o(res_valid),
    .out_ready_i(res_ready),
    .out_data_o (res_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Lamps follow the mode code directly
  function automatic out_item_t lamps_for(logic [2:0] code);
    out_item_t r;
    r.mode       = code;
    r.delay_lamp = (code == CODE_DELAY);
    r.pump_on    = (code == CODE_FILL);
    r.full_lamp  = (code == CODE_FULL);
    r.alarm      = (code == CODE_EMERG);
    return r;
  endfunction

  // One tick of the controller: debounce every lane, then step the mode machine
  function automatic out_item_t step_controller(in_item_t t);
    logic [Lanes-1:0] raw;
    logic [Lanes-1:0] press;
    int               i;
    raw[LANE_START] = t.start_level;
    raw[LANE_STOP]  = t.stop_level;
    raw[LANE_EMERG] = t.emergency_level;
    raw[LANE_LOW]   = t.low_level;
    raw[LANE_HIGH]  = t.high_level;
    press = '0;
    for (i = 0; i < Lanes; i++) begin
      if (raw[i] != raw_prev[i]) begin
        raw_prev[i]  = raw[i];
        quiet_cnt[i] = '0;
      end else if (quiet_cnt[i] != CountMax) begin
        quiet_cnt[i] = quiet_cnt[i] + 1'b1;
      end
      if (quiet_cnt[i] >= debounce_thr && raw[i] != lvl_stable[i]) begin
        lvl_stable[i] = raw[i];
        press[i]      = ~raw[i];
      end
    end

    if (press[LANE_EMERG]) begin
      ctl_mode = (ctl_mode != CODE_EMERG) ? CODE_EMERG : CODE_IDLE;
    end
    if (ctl_mode != CODE_EMERG) begin
      if (press[LANE_STOP]) begin
        ctl_mode = CODE_IDLE;
      end
      if (press[LANE_START] && (ctl_mode == CODE_IDLE || ctl_mode == CODE_FULL)) begin
        ctl_mode = CODE_RUN;
      end
      // high water has priority over low water
      if (!lvl_stable[LANE_HIGH] &&
          (ctl_mode == CODE_RUN || ctl_mode == CODE_DELAY || ctl_mode == CODE_FILL)) begin
        ctl_mode = CODE_FULL;
      end else if (!lvl_stable[LANE_LOW] &&
                   (ctl_mode == CODE_RUN || ctl_mode == CODE_FULL)) begin
        ctl_mode  = CODE_DELAY;
        delay_cnt = '0;
      end
      if (ctl_mode == CODE_DELAY) begin
        if (delay_cnt >= pump_thr) begin
          ctl_mode = CODE_FILL;
        end else if (delay_cnt != CountMax) begin
          delay_cnt = delay_cnt + 1'b1;
        end
      end
    end
    return lamps_for(ctl_mode);
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] result %0d: %s", $time, n_results, msg);
    n_errors++;
  endtask

  // Offer one tick, with random idle cycles in front of it
  task automatic send_tick(in_item_t t, logic typed, out_item_t want);
    while ($urandom_range(99, 0) < snd_idle_pct) begin
      tick_valid <= 1'b0;
      @(posedge clk);
    end
    tick_valid <= 1'b1;
    tick_data  <= t;
    row_typed  <= typed;
    row_result <= want;
    @(posedge clk);
    while (!tick_ready) @(posedge clk);
  endtask

  // Stop sending and wait until every outstanding result is back;
  // the queue is checked only once the last accepted tick is in it
  task automatic drain_results();
    tick_valid <= 1'b0;
    @(posedge clk);
    while (expected_modes.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [IdxWidth-1:0] idx, logic [CfgWidth-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_DEBOUNCE) begin
      debounce_thr = val;
    end else if (idx == CFG_PUMP_DELAY) begin
      pump_thr = val;
    end
    @(posedge clk);
  endtask

  // Result receiver readiness
  always @(posedge clk) begin
    res_ready <= ($urandom_range(99, 0) >= rcv_stall_pct);
  end

  // Predict on every accepted tick, check every accepted result
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (tick_valid && tick_ready) begin
        want = step_controller(tick_data);
        if (row_typed) begin
          want = row_result;
        end
        expected_modes.push_back(want);
        n_ticks++;
      end
      if (res_valid && res_ready) begin
        if (res_data.mode <= CODE_EMERG) begin
          mode_hits[res_data.mode]++;
        end
        if (expected_modes.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction, mode %0d", res_data.mode));
        end else begin
          want = expected_modes.pop_front();
          if (res_data.mode !== want.mode)
            report_mismatch($sformatf("mode %0d, want %0d", res_data.mode, want.mode));
          if (res_data.delay_lamp !== want.delay_lamp)
            report_mismatch($sformatf("delay_lamp %b, want %b",
                                      res_data.delay_lamp, want.delay_lamp));
          if (res_data.pump_on !== want.pump_on)
            report_mismatch($sformatf("pump_on %b, want %b", res_data.pump_on, want.pump_on));
          if (res_data.full_lamp !== want.full_lamp)
            report_mismatch($sformatf("full_lamp %b, want %b",
                                      res_data.full_lamp, want.full_lamp));
          if (res_data.alarm !== want.alarm)
            report_mismatch($sformatf("alarm %b, want %b", res_data.alarm, want.alarm));
        end
        n_results++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycles, expected_modes.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int unsigned r;
    int unsigned p;
    int unsigned k;
    int unsigned sent;
    int unsigned seg_len;
    int unsigned hold_cap;
    in_item_t    seg;

    // Model state after reset
    raw_prev     = '1;
    lvl_stable   = '1;
    ctl_mode     = CODE_IDLE;
    delay_cnt    = '0;
    debounce_thr = DebounceReset;
    pump_thr     = PumpDelayReset;
    for (r = 0; r < Lanes; r++) begin
      quiet_cnt[r] = '0;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed ticks; thresholds dropped to zero partway through
    n_settings = 1;
    for (r = 0; r < NumRows; r++) begin
      if (r == CfgRow) begin
        drain_results();
        write_reg(CFG_DEBOUNCE, '0);
        write_reg(CFG_PUMP_DELAY, '0);
        n_settings++;
      end
      send_tick(in_item_t'(dir_rows[r].levels), dir_rows[r].typed,
                lamps_for(dir_rows[r].mode));
    end

    // Random phases: held level patterns with the odd one-tick glitch
    for (p = 0; p < NumPhases; p++) begin
      drain_results();
      snd_idle_pct  = phases[p].snd_idle;
      rcv_stall_pct = phases[p].rcv_stall;
      write_reg(CFG_DEBOUNCE, phases[p].deb);
      write_reg(CFG_PUMP_DELAY, phases[p].pump);
      if (phases[p].poke_spare) begin
        write_reg(CFG_SPARE_LO, CfgWidth'($urandom));
        write_reg(CFG_SPARE_HI, CfgWidth'($urandom));
      end
      n_settings++;
      hold_cap = (phases[p].deb > 6) ? 6 : 32'(phases[p].deb);
      sent = 0;
      while (sent < phases[p].ticks) begin
        seg.start_level     = ($urandom_range(99, 0) >= 12);
        seg.stop_level      = ($urandom_range(99, 0) >= 8);
        seg.emergency_level = ($urandom_range(99, 0) >= 6);
        seg.low_level       = ($urandom_range(99, 0) >= 45);
        seg.high_level      = ($urandom_range(99, 0) >= 15);
        seg_len = ($urandom_range(4, 0) == 0) ? 1 : $urandom_range(hold_cap + 4, hold_cap + 1);
        for (k = 0; k < seg_len && sent < phases[p].ticks; k++) begin
          send_tick(seg, 1'b0, '0);
          sent++;
          if (p == HoldPhase && sent == phases[p].ticks / 2) begin
            drain_results();
          end
        end
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    $display("Covered %0d ticks and %0d results over %0d threshold settings",
             n_ticks, n_results, n_settings);
    $display("Results per mode idle/run/delay/fill/full/emergency: %0d/%0d/%0d/%0d/%0d/%0d",
             mode_hits[CODE_IDLE], mode_hits[CODE_RUN], mode_hits[CODE_DELAY],
             mode_hits[CODE_FILL], mode_hits[CODE_FULL], mode_hits[CODE_EMERG]);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
